>>> hw/rtl/egcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package egcd_pkg;

  // Sequencer states.
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Commands from the sequencer to the arithmetic unit and output register.
  typedef struct packed {
    logic load;    // capture a new operand pair
    logic step;    // perform one reduction step
    logic finish;  // move the result into the output register
  } ctl_t;

  // Status from the arithmetic unit back to the sequencer.
  typedef struct packed {
    logic done;    // one operand has reached zero
  } sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/egcd_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module egcd_unit #(
  parameter int WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire egcd_pkg::ctl_t       ctl,
  input  wire logic [WIDTH-1:0]     in_a,
  input  wire logic [WIDTH-1:0]     in_b,
  output egcd_pkg::sts_t            sts,
  output logic      [WIDTH-1:0]     result
);

  localparam int KW = $clog2(WIDTH);

  logic [WIDTH-1:0] a_r, a_nxt;
  logic [WIDTH-1:0] b_r, b_nxt;
  logic [KW-1:0]    k_r, k_nxt;

  // Shared subtractor and compare: borrow tells which operand is larger.
  logic [WIDTH:0]   sub_full;
  logic             a_lt_b;
  logic [WIDTH-1:0] diff_mag;

  assign sub_full = {1'b0, a_r} - {1'b0, b_r};
  assign a_lt_b   = sub_full[WIDTH];
  assign diff_mag = a_lt_b ? (~sub_full[WIDTH-1:0] + {{(WIDTH-1){1'b0}}, 1'b1})
                           : sub_full[WIDTH-1:0];

  // Load a new operand pair, or do one binary reduction step: strip common or single
  // factors of two, otherwise replace the larger odd operand by half the difference.
  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    k_nxt = k_r;
    if (ctl.load) begin
      a_nxt = in_a;
      b_nxt = in_b;
      k_nxt = '0;
    end else if (ctl.step) begin
      priority if (!a_r[0] && !b_r[0]) begin
        a_nxt = a_r >> 1;
        b_nxt = b_r >> 1;
        k_nxt = k_r + 1'b1;
      end else if (!a_r[0]) begin
        a_nxt = a_r >> 1;
      end else if (!b_r[0]) begin
        b_nxt = b_r >> 1;
      end else if (a_lt_b) begin
        b_nxt = diff_mag >> 1;
      end else begin
        a_nxt = diff_mag >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    k_r <= k_nxt;
  end

  // Once one operand is zero the other holds the odd part of the divisor.
  assign sts.done = (a_r == '0) || (b_r == '0);
  assign result   = (a_r | b_r) << k_r;

endmodule

`default_nettype wire

>>> hw/rtl/egcd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module egcd_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire egcd_pkg::sts_t sts,
  input  wire logic           out_room,
  output logic                in_stall,
  output egcd_pkg::ctl_t      ctl
);

  egcd_pkg::state_t state_r, state_nxt;

  // Next state: a request starts a run, the run ends when a result is handed off.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      egcd_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = egcd_pkg::ST_RUN;
        end
      end
      egcd_pkg::ST_RUN: begin
        if (sts.done && out_room) begin
          state_nxt = egcd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = egcd_pkg::ST_IDLE;
    endcase
  end

  // Outputs decoded from the current state.
  always_comb begin
    in_stall   = 1'b1;
    ctl.load   = 1'b0;
    ctl.step   = 1'b0;
    ctl.finish = 1'b0;
    unique case (state_r)
      egcd_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        ctl.load = in_valid;
      end
      egcd_pkg::ST_RUN: begin
        ctl.step   = !sts.done;
        ctl.finish = sts.done && out_room;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= egcd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/euclid_gcd.sv
// Operation: an accepted request is loaded into the arithmetic unit, which then repeats
// passes through its shared subtract and shift logic until one operand is zero, then
// hands the result off, waiting while a full output register is stalled.
// Throughput: one request at a time; a new request is taken as soon as the previous
// result is in the output register.
// Reset: synchronous active-low rst_n clears the sequencer and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module euclid_gcd #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [WIDTH-1:0] in_operand_a,
  input  wire logic [WIDTH-1:0] in_operand_b,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [WIDTH-1:0] out_divisor
);

  egcd_pkg::ctl_t   ctl;
  egcd_pkg::sts_t   sts;
  logic [WIDTH-1:0] result;
  logic             out_valid_r, out_valid_nxt;
  logic [WIDTH-1:0] out_divisor_r;
  logic             out_room;

  // The output register can take a result when empty or when drained this cycle.
  assign out_room = !out_valid_r || !out_stall;

  egcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .out_room (out_room),
    .in_stall (in_stall),
    .ctl      (ctl)
  );

  egcd_unit #(
    .WIDTH (WIDTH)
  ) u_unit (
    .clk    (clk),
    .ctl    (ctl),
    .in_a   (in_operand_a),
    .in_b   (in_operand_b),
    .sts    (sts),
    .result (result)
  );

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.finish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_divisor_r <= result;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_divisor = out_divisor_r;

`ifndef SYNTH
  // An accepted request makes the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after accepting a request");

  // A result is only moved out when the output register has room.
  a_finish_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.finish |-> out_room)
    else $error("result moved into an occupied output register");

  // Load, step and finish never coincide.
  a_ctl_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.load, ctl.step, ctl.finish}))
    else $error("conflicting unit commands");

  // A finished result appears on the output the following cycle.
  a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.finish |=> out_valid)
    else $error("finished result not presented");
`endif

endmodule

`default_nettype wire
